@@ design/nnis_pkg.sv @@
`timescale 1ns / 1ps
package nnis_pkg;

  // image limits
  localparam int MAX_SRC_WIDTH  = 128;
  localparam int MAX_SRC_HEIGHT = 128;
  localparam int MAX_DST_DIM    = 1024;

  // field and register widths
  localparam int COORD_W = 10;
  localparam int PIX_W   = 32;
  localparam int SRC_W   = 8;
  localparam int DST_W   = 11;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  // source store
  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // scale unit: product of coordinate and source size, quotient below the source size
  localparam int PROD_W = COORD_W + SRC_W;
  localparam int Q_W    = $clog2((MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                                 MAX_SRC_WIDTH : MAX_SRC_HEIGHT);
  localparam int STEP_W = (Q_W > 1) ? $clog2(Q_W) : 1;

  // register map
  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_t;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // effective (clamped) image sizes
  typedef struct packed {
    logic [SRC_W-1:0] src_w;
    logic [SRC_W-1:0] src_h;
    logic [DST_W-1:0] dst_w;
    logic [DST_W-1:0] dst_h;
  } sizes_t;

  // request to the scale unit
  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] coord;
    logic [SRC_W-1:0]   size;
    logic [DST_W-1:0]   divisor;
  } scl_req_t;

  // result of the scale unit
  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } scl_rsp_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_X,
    ST_DIV_Y,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

@@ design/nnis_ram.sv @@
`timescale 1ns / 1ps
module nnis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/nnis_regs.sv @@
`timescale 1ns / 1ps
module nnis_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nnis_pkg::PADDR_W-1:0] paddr,
  input  logic [nnis_pkg::DATA_W-1:0]  pwdata,
  output logic [nnis_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output nnis_pkg::sizes_t             sizes
);
  import nnis_pkg::*;

  logic [SRC_W-1:0] src_w_r, src_w_nxt;
  logic [SRC_W-1:0] src_h_r, src_h_nxt;
  logic [DST_W-1:0] dst_w_r, dst_w_nxt;
  logic [DST_W-1:0] dst_h_r, dst_h_nxt;
  reg_idx_t         idx;
  logic             wr_en;

  // zero counts as one, oversize counts as the limit
  function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] v,
                                                 input logic [SRC_W-1:0] lim);
    logic [SRC_W-1:0] r;
    if (v == '0) begin
      r = SRC_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [DST_W-1:0] clamp_dst(input logic [DST_W-1:0] v,
                                                 input logic [DST_W-1:0] lim);
    logic [DST_W-1:0] r;
    if (v == '0) begin
      r = DST_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_comb begin
    src_w_nxt = src_w_r;
    src_h_nxt = src_h_r;
    dst_w_nxt = dst_w_r;
    dst_h_nxt = dst_h_r;
    if (wr_en) begin
      unique case (idx)
        REG_SRC_WIDTH:  src_w_nxt = pwdata[SRC_W-1:0];
        REG_SRC_HEIGHT: src_h_nxt = pwdata[SRC_W-1:0];
        REG_DST_WIDTH:  dst_w_nxt = pwdata[DST_W-1:0];
        REG_DST_HEIGHT: dst_h_nxt = pwdata[DST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SRC_W'(64);
      src_h_r <= SRC_W'(64);
      dst_w_r <= DST_W'(64);
      dst_h_r <= DST_W'(64);
    end else begin
      src_w_r <= src_w_nxt;
      src_h_r <= src_h_nxt;
      dst_w_r <= dst_w_nxt;
      dst_h_r <= dst_h_nxt;
    end
  end

  // readback of the bits written
  always_comb begin
    unique case (idx)
      REG_SRC_WIDTH:  prdata = DATA_W'(src_w_r);
      REG_SRC_HEIGHT: prdata = DATA_W'(src_h_r);
      REG_DST_WIDTH:  prdata = DATA_W'(dst_w_r);
      REG_DST_HEIGHT: prdata = DATA_W'(dst_h_r);
      default:        prdata = '0;
    endcase
  end

  // sizes seen by the datapath
  assign sizes.src_w = clamp_src(src_w_r, SRC_W'(MAX_SRC_WIDTH));
  assign sizes.src_h = clamp_src(src_h_r, SRC_W'(MAX_SRC_HEIGHT));
  assign sizes.dst_w = clamp_dst(dst_w_r, DST_W'(MAX_DST_DIM));
  assign sizes.dst_h = clamp_dst(dst_h_r, DST_W'(MAX_DST_DIM));

endmodule

@@ design/nnis_scale.sv @@
`timescale 1ns / 1ps
module nnis_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  nnis_pkg::scl_req_t req,
  output nnis_pkg::scl_rsp_t rsp
);
  import nnis_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [DST_W-1:0]  div_r, div_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PROD_W-1:0] trial;
  logic              ge;

  // shifted divisor for the current quotient bit
  assign trial = PROD_W'(div_r) << step_r;
  assign ge    = (rem_r >= trial);

  // load the product, then one restoring step per cycle, msb first
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    if (req.start) begin
      rem_nxt  = PROD_W'(req.coord) * PROD_W'(req.size);
      div_nxt  = req.divisor;
      q_nxt    = '0;
      step_nxt = STEP_W'(Q_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - trial;
      end
      q_nxt = {q_r[Q_W-2:0], ge};
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

@@ design/nearest_neighbor_image_scaler.sv @@
`timescale 1ns / 1ps
// Nearest-neighbor scaler over a 128x128 store of 32-bit RGBA source pixels. A write word
// (req_type 0) stores pixel_in at source column coord_x, row coord_y, is dropped when outside
// the configured source size, and gives no result. A read word (req_type 1)
// names an output pixel, maps it to floor(x*src_width/dst_width), floor(y*src_height/dst_height)
// and returns the stored pixel; outside the output size it returns zero with coord_error set.
// A read in range uses the single shared multiply-divide unit, which forms both coordinates
// in turn at one quotient bit per cycle, followed by the registered store read. in_stall stays
// high while a word is in work; a finished result sits in the output register, so the next
// word is taken while it waits. The user must program the sizes over the register port while
// idle, which the block itself leaves unchecked; zero counts as one and oversize values as
// the limit. Reading a source pixel that was never written gives an undefined pixel.
module nearest_neighbor_image_scaler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [nnis_pkg::COORD_W-1:0] in_coord_x,
  input  logic [nnis_pkg::COORD_W-1:0] in_coord_y,
  input  logic [nnis_pkg::PIX_W-1:0]   in_pixel_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nnis_pkg::PIX_W-1:0]   out_pixel_out,
  output logic                         out_coord_error,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nnis_pkg::PADDR_W-1:0] paddr,
  input  logic [nnis_pkg::DATA_W-1:0]  pwdata,
  output logic [nnis_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import nnis_pkg::*;

  state_t             state_r, state_nxt;
  sizes_t             sizes;
  scl_req_t           scl_req;
  scl_rsp_t           scl_rsp;

  logic               kind_r;
  logic [COORD_W-1:0] cx_r, cy_r;
  logic [PIX_W-1:0]   pix_r;
  logic [Q_W-1:0]     sx_r, sx_nxt;
  logic [PIX_W-1:0]   res_pix_r, res_pix_nxt;
  logic               res_err_r, res_err_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_pix_r, out_pix_nxt;
  logic               out_err_r, out_err_nxt;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [PIX_W-1:0]   ram_rdata;

  logic               in_acc;
  logic               src_hit, dst_miss;

  nnis_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sizes   (sizes)
  );

  nnis_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scl_req),
    .rsp   (scl_rsp)
  );

  nnis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pix_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // range checks on the captured word
  assign src_hit  = ({1'b0, cx_r} < (COORD_W + 1)'(sizes.src_w)) &&
                    ({1'b0, cy_r} < (COORD_W + 1)'(sizes.src_h));
  assign dst_miss = ({1'b0, cx_r} >= (COORD_W + 1)'(sizes.dst_w)) ||
                    ({1'b0, cy_r} >= (COORD_W + 1)'(sizes.dst_h));

  // store addresses, row-major
  assign ram_waddr = ADDR_W'(cy_r) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(cx_r);
  assign ram_raddr = ADDR_W'(scl_rsp.quot) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(sx_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sx_nxt        = sx_r;
    res_pix_nxt   = res_pix_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pix_nxt   = out_pix_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    scl_req       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (kind_r == REQ_WRITE) begin
          ram_we    = src_hit;
          state_nxt = ST_IDLE;
        end else if (dst_miss) begin
          res_pix_nxt = '0;
          res_err_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          scl_req.start   = 1'b1;
          scl_req.coord   = cx_r;
          scl_req.size    = sizes.src_w;
          scl_req.divisor = sizes.dst_w;
          state_nxt       = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (scl_rsp.done) begin
          sx_nxt          = scl_rsp.quot;
          scl_req.start   = 1'b1;
          scl_req.coord   = cy_r;
          scl_req.size    = sizes.src_h;
          scl_req.divisor = sizes.dst_h;
          state_nxt       = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (scl_rsp.done) begin
          ram_re    = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        res_pix_nxt = ram_rdata;
        res_err_nxt = 1'b0;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = res_pix_r;
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // captured word and results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_req_type;
      cx_r   <= in_coord_x;
      cy_r   <= in_coord_y;
      pix_r  <= in_pixel_in;
    end
    sx_r      <= sx_nxt;
    res_pix_r <= res_pix_nxt;
    res_err_r <= res_err_nxt;
    out_pix_r <= out_pix_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pix_r;
  assign out_coord_error = out_err_r;

endmodule

@@ design/nnis_chk.sv @@
`timescale 1ns / 1ps
module nnis_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [nnis_pkg::PIX_W-1:0] out_pixel_out,
  input logic                       out_coord_error
);

  // one word at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous word in work");

  // no result can show up the cycle right after a word is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // error results carry a zero pixel
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coord_error) |-> (out_pixel_out == '0))
    else $error("error result with nonzero pixel");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_pixel_out) && $stable(out_coord_error)))
    else $error("stalled result word changed");

endmodule

bind nearest_neighbor_image_scaler nnis_chk u_nnis_chk (.*);
